// ----- sv/kpc_pkg.sv -----
// Shared types and constants of the key press classifier.
`default_nettype none
package kpc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HOLD     = 2'd2,
    ST_RELEASED = 2'd3
  } kpc_state_t;

  localparam logic [1:0] RAW_PRESSED  = 2'd1;
  localparam logic [1:0] RAW_RELEASED = 2'd2;

  localparam logic [1:0] MODE_SHORT          = 2'd0;
  localparam logic [1:0] MODE_SHORT_REPEATED = 2'd1;
  localparam logic [1:0] MODE_SHORT_OR_LONG  = 2'd2;

  localparam logic EV_SHORT = 1'b0;
  localparam logic EV_LONG  = 1'b1;

  localparam logic CFG_HOLD_TIME       = 1'b0;
  localparam logic CFG_REPEAT_INTERVAL = 1'b1;

  localparam int KEY_W       = 5;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // classified item handed from front to back
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    kpc_state_t        st;
    logic [TIME_W-1:0] now;
    logic [1:0]        mode;
  } kpc_item_t;

  // per-key state word
  typedef struct packed {
    kpc_state_t        st;
    logic              held;
    logic [TIME_W-1:0] last_short;
  } kpc_entry_t;

  // queue status toward the front
  typedef struct packed {
    logic full;
    logic empty;
  } kpc_qstat_t;

endpackage
`default_nettype wire

// ----- sv/key_press_classifier.sv -----
// Top level of the per-key short/long press classifier with auto-repeat.
// Takes one key report per cycle and issues at most one short or long press event for it;
// m_tvalid is registered, behind a queue slot and the item register. A stalled output
// backs up through a four-entry queue before s_tready drops. The rate is set by the per-key
// read-modify-write in the back end, which forwards its own write so that reports of one key
// may follow each other back to back. Per-key state sits in a KEY_COUNT-entry memory whose
// entries read as idle until first written, tracked by one valid flop per key, so no clearing
// pass is needed. Key indexes not below KEY_COUNT are dropped. Configuration registers:
// 0 hold time, 1 repeat interval, both in milliseconds; write them only while the block is idle.
`default_nettype none
module key_press_classifier #(
  parameter int KEY_COUNT = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // key_index, raw_state, pressed_at_ms, now_ms, repeat_mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // event_key
  output logic             m_tuser,   // event_kind
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [kpc_pkg::CFG_W-1:0] hold_time_ms;
  logic [kpc_pkg::CFG_W-1:0] repeat_interval_ms;

  kpc_pkg::kpc_qstat_t qstat;
  kpc_pkg::kpc_item_t  push_item;
  kpc_pkg::kpc_item_t  head;
  logic                push;
  logic                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time_ms       <= 16'd500;
      repeat_interval_ms <= 16'd125;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpc_pkg::CFG_HOLD_TIME:       hold_time_ms       <= cfg_data;
        kpc_pkg::CFG_REPEAT_INTERVAL: repeat_interval_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  kpc_front #(
    .KEY_COUNT(KEY_COUNT)
  ) u_front (
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .hold_time_ms (hold_time_ms),
    .qstat        (qstat),
    .push         (push),
    .item         (push_item)
  );

  kpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  kpc_back #(
    .KEY_COUNT(KEY_COUNT)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .qstat              (qstat),
    .head               (head),
    .pop                (pop),
    .repeat_interval_ms (repeat_interval_ms),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .m_tuser            (m_tuser)
  );

endmodule
`default_nettype wire

// ----- sv/kpc_front.sv -----
// Front end: input handshake, key range check and derivation of the key state.
`default_nettype none
module kpc_front #(
  parameter int KEY_COUNT = 25
) (
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [kpc_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  wire logic [kpc_pkg::CFG_W-1:0]        hold_time_ms,
  input  wire kpc_pkg::kpc_qstat_t              qstat,
  output logic                                  push,
  output kpc_pkg::kpc_item_t                    item
);

  logic [kpc_pkg::KEY_W-1:0]  key_index;
  logic [1:0]                 raw_state;
  logic [kpc_pkg::TIME_W-1:0] pressed_at_ms;
  logic [kpc_pkg::TIME_W-1:0] now_ms;
  logic [1:0]                 repeat_mode;
  logic [kpc_pkg::TIME_W-1:0] elapsed;
  logic                       in_range;

  assign key_index     = s_tdata[4:0];
  assign raw_state     = s_tdata[6:5];
  assign pressed_at_ms = s_tdata[38:7];
  assign now_ms        = s_tdata[70:39];
  assign repeat_mode   = s_tdata[72:71];

  assign elapsed  = now_ms - pressed_at_ms;
  assign in_range = 9'(key_index) < 9'(KEY_COUNT);

  assign s_tready = !qstat.full;
  assign push     = s_tvalid && s_tready && in_range;

  always_comb begin
    item.key  = key_index;
    item.now  = now_ms;
    item.mode = repeat_mode;
    priority if (raw_state == kpc_pkg::RAW_PRESSED) begin
      item.st = (elapsed > {16'd0, hold_time_ms}) ? kpc_pkg::ST_HOLD : kpc_pkg::ST_PRESSED;
    end else if (raw_state == kpc_pkg::RAW_RELEASED) begin
      item.st = kpc_pkg::ST_RELEASED;
    end else begin
      item.st = kpc_pkg::ST_IDLE;
    end
  end

endmodule
`default_nettype wire

// ----- sv/kpc_queue.sv -----
// Short queue of classified items between front and back.
`default_nettype none
module kpc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire kpc_pkg::kpc_item_t   push_item,
  input  wire logic                 pop,
  output kpc_pkg::kpc_item_t        head,
  output kpc_pkg::kpc_qstat_t       qstat
);

  kpc_pkg::kpc_item_t          slots [kpc_pkg::QUEUE_DEPTH];
  logic [kpc_pkg::QPTR_W-1:0]  wr_ptr;
  logic [kpc_pkg::QPTR_W-1:0]  rd_ptr;
  logic [kpc_pkg::QPTR_W:0]    count;
  logic [kpc_pkg::QPTR_W:0]    count_next;

  assign head        = slots[rd_ptr];
  assign qstat.full  = count == (kpc_pkg::QPTR_W+1)'(kpc_pkg::QUEUE_DEPTH);
  assign qstat.empty = count == '0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- sv/kpc_back.sv -----
// Back end: per-key state memory, event rules and output register.
`default_nettype none
module kpc_back #(
  parameter int KEY_COUNT = 25
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire kpc_pkg::kpc_qstat_t            qstat,
  input  wire kpc_pkg::kpc_item_t             head,
  output logic                                pop,
  input  wire logic [kpc_pkg::CFG_W-1:0]      repeat_interval_ms,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [kpc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                m_tuser
);

  localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam kpc_pkg::kpc_entry_t ENTRY_RESET = '{kpc_pkg::ST_IDLE, 1'b0, '0};

  kpc_pkg::kpc_entry_t mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] written;

  // item in work
  logic                  busy;
  kpc_pkg::kpc_item_t    it;
  kpc_pkg::kpc_entry_t   rd_data;
  logic                  rd_written;
  logic                  fwd;
  kpc_pkg::kpc_entry_t   fwd_data;

  kpc_pkg::kpc_entry_t   cur;
  kpc_pkg::kpc_entry_t   upd;
  logic                  ev;
  logic                  ev_kind;
  logic                  gate;
  logic                  advance;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;

  logic                      out_valid;
  logic [kpc_pkg::KEY_W-1:0] out_key;
  logic                      out_kind;

  assign rd_addr = AW'(head.key);
  assign wr_addr = AW'(it.key);

  always_comb begin
    priority if (fwd) begin
      cur = fwd_data;
    end else if (rd_written) begin
      cur = rd_data;
    end else begin
      cur = ENTRY_RESET;
    end
  end

  assign gate = (it.now - cur.last_short) > {16'd0, repeat_interval_ms};

  always_comb begin
    upd     = cur;
    upd.st  = it.st;
    ev      = 1'b0;
    ev_kind = kpc_pkg::EV_SHORT;
    unique case (it.st)
      kpc_pkg::ST_PRESSED: begin
        if ((it.mode == kpc_pkg::MODE_SHORT || it.mode == kpc_pkg::MODE_SHORT_REPEATED)
            && cur.st != kpc_pkg::ST_PRESSED && gate) begin
          ev             = 1'b1;
          upd.last_short = it.now;
        end
      end
      kpc_pkg::ST_HOLD: begin
        if (it.mode == kpc_pkg::MODE_SHORT_OR_LONG && cur.st != kpc_pkg::ST_HOLD) begin
          ev       = 1'b1;
          ev_kind  = kpc_pkg::EV_LONG;
          upd.held = 1'b1;
        end else if (it.mode == kpc_pkg::MODE_SHORT_REPEATED && gate) begin
          ev             = 1'b1;
          upd.last_short = it.now;
        end
      end
      kpc_pkg::ST_RELEASED: begin
        if (it.mode == kpc_pkg::MODE_SHORT_OR_LONG && !cur.held
            && cur.st != kpc_pkg::ST_RELEASED && gate) begin
          ev             = 1'b1;
          upd.last_short = it.now;
        end
        upd.held = 1'b0;
      end
      kpc_pkg::ST_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  assign advance = busy && !(ev && out_valid && !m_tready);
  assign pop     = !qstat.empty && (!busy || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      written   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (advance) begin
        busy <= 1'b0;
      end
      if (advance) begin
        written[wr_addr] <= 1'b1;
      end
      if (advance && ev) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      it         <= head;
      rd_written <= written[rd_addr];
      fwd        <= advance && (it.key == head.key);
      fwd_data   <= upd;
    end
    if (advance && ev) begin
      out_key  <= it.key;
      out_kind <= ev_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mem[wr_addr] <= upd;
    end
    if (pop) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_key};
  assign m_tuser  = out_kind;

endmodule
`default_nettype wire

// ----- sv/kpc_checker.sv -----
// Port-level checks of the key press classifier and their binding to the top level.
`default_nettype none
module kpc_checker #(
  parameter int KEY_COUNT = 25
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tuser
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("event pending right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:5] == 3'd0 && 9'(m_tdata[4:0]) < 9'(KEY_COUNT)))
    else $error("event for a key out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled event changed");

endmodule

bind key_press_classifier kpc_checker #(
  .KEY_COUNT(KEY_COUNT)
) u_kpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

// ----- sim/kpc_event_checker.sv -----
// Checker for key_press_classifier: predicts press events from accepted reports and compares.
module kpc_event_checker #(
  parameter int KEY_COUNT = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [kpc_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [kpc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            m_tuser,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [kpc_pkg::CFG_W-1:0]       cfg_data,
  output int                              outstanding,
  output int                              failures
);
  timeunit 1ns;
  timeprecision 1ps;

  // report fields, lowest bits first: key, raw, pressed_at, now, mode
  typedef struct packed {
    logic [6:0]                 pad;
    logic [1:0]                 mode;
    logic [kpc_pkg::TIME_W-1:0] now;
    logic [kpc_pkg::TIME_W-1:0] pressed_at;
    logic [1:0]                 raw;
    logic [kpc_pkg::KEY_W-1:0]  key;
  } key_report_t;

  typedef struct packed {
    logic [kpc_pkg::KEY_W-1:0] key;
    logic                      kind;
  } press_event_t;

  localparam logic [kpc_pkg::CFG_W-1:0] HOLD_RESET_MS   = 16'd500;
  localparam logic [kpc_pkg::CFG_W-1:0] REPEAT_RESET_MS = 16'd125;

  kpc_pkg::kpc_state_t        key_st     [KEY_COUNT];
  logic                       key_held   [KEY_COUNT];
  logic [kpc_pkg::TIME_W-1:0] last_short [KEY_COUNT];
  logic [kpc_pkg::CFG_W-1:0]  hold_ms;
  logic [kpc_pkg::CFG_W-1:0]  repeat_ms;
  press_event_t               event_q [$];
  int                         fail_cnt;

  function automatic bit repeat_gate_open(int k, logic [kpc_pkg::TIME_W-1:0] now);
    logic [kpc_pkg::TIME_W-1:0] since;
    since = now - last_short[k];
    if (since > {16'd0, repeat_ms}) begin
      last_short[k] = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit classify_report(key_report_t rep, output press_event_t ev);
    logic [kpc_pkg::TIME_W-1:0] elapsed;
    kpc_pkg::kpc_state_t        st;
    kpc_pkg::kpc_state_t        prev;
    bit                         fire;
    int                         k;
    fire = 1'b0;
    ev   = '0;
    if (int'(rep.key) >= KEY_COUNT) return 1'b0;
    k       = int'(rep.key);
    elapsed = rep.now - rep.pressed_at;
    if (rep.raw == kpc_pkg::RAW_PRESSED) begin
      st = (elapsed > {16'd0, hold_ms}) ? kpc_pkg::ST_HOLD : kpc_pkg::ST_PRESSED;
    end else if (rep.raw == kpc_pkg::RAW_RELEASED) begin
      st = kpc_pkg::ST_RELEASED;
    end else begin
      st = kpc_pkg::ST_IDLE;
    end
    prev   = key_st[k];
    ev.key = rep.key;
    case (st)
      kpc_pkg::ST_PRESSED: begin
        if ((rep.mode == kpc_pkg::MODE_SHORT || rep.mode == kpc_pkg::MODE_SHORT_REPEATED)
            && prev != kpc_pkg::ST_PRESSED) begin
          fire    = repeat_gate_open(k, rep.now);
          ev.kind = kpc_pkg::EV_SHORT;
        end
      end
      kpc_pkg::ST_HOLD: begin
        if (rep.mode == kpc_pkg::MODE_SHORT_OR_LONG && prev != kpc_pkg::ST_HOLD) begin
          key_held[k] = 1'b1;
          fire        = 1'b1;
          ev.kind     = kpc_pkg::EV_LONG;
        end else if (rep.mode == kpc_pkg::MODE_SHORT_REPEATED) begin
          fire    = repeat_gate_open(k, rep.now);
          ev.kind = kpc_pkg::EV_SHORT;
        end
      end
      kpc_pkg::ST_RELEASED: begin
        if (rep.mode == kpc_pkg::MODE_SHORT_OR_LONG && !key_held[k]
            && prev != kpc_pkg::ST_RELEASED) begin
          fire    = repeat_gate_open(k, rep.now);
          ev.kind = kpc_pkg::EV_SHORT;
        end
        key_held[k] = 1'b0;
      end
      default: ;
    endcase
    key_st[k] = st;
    return fire;
  endfunction

  always @(posedge clk) begin : watch
    key_report_t  rep;
    press_event_t ev;
    press_event_t exp_ev;
    if (rst) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        key_st[k]     = kpc_pkg::ST_IDLE;
        key_held[k]   = 1'b0;
        last_short[k] = '0;
      end
      hold_ms   = HOLD_RESET_MS;
      repeat_ms = REPEAT_RESET_MS;
      event_q.delete();
      fail_cnt = 0;
      outstanding <= 0;
      failures    <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == kpc_pkg::CFG_HOLD_TIME) hold_ms = cfg_data;
        else repeat_ms = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        rep = s_tdata;
        if (classify_report(rep, ev)) event_q.push_back(ev);
      end
      if (m_tvalid && m_tready) begin
        if (event_q.size() == 0) begin
          $error("unexpected event: key %0d kind %0d", m_tdata, m_tuser);
          fail_cnt++;
        end else begin
          exp_ev = event_q.pop_front();
          if (m_tdata !== {{(kpc_pkg::OUT_TDATA_W-kpc_pkg::KEY_W){1'b0}}, exp_ev.key}) begin
            $error("event_key: expected %0d, got %0d", exp_ev.key, m_tdata);
            fail_cnt++;
          end
          if (m_tuser !== exp_ev.kind) begin
            $error("event_kind: expected %0d, got %0d", exp_ev.kind, m_tuser);
            fail_cnt++;
          end
        end
      end
      outstanding <= event_q.size();
      failures    <= fail_cnt;
    end
  end

endmodule

// ----- sim/key_press_classifier_tb.sv -----
// Testbench top for key_press_classifier: key report stimulus, flow control and verdict.
module key_press_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         KEY_COUNT         = 25;
  localparam logic [1:0] RAW_IDLE          = 2'd0;
  localparam logic [1:0] RAW_INVALID       = 2'd3;
  localparam logic [1:0] MODE_NONE         = 2'd3;
  localparam int         DRAIN_CYCLES      = 16;
  localparam int         LONG_STALL_CYCLES = 150;
  localparam int         PHASE_REPORTS     = 300;
  localparam int         PHASES            = 5;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [kpc_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [kpc_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tuser;
  logic                            cfg_we;
  logic                            cfg_index;
  logic [kpc_pkg::CFG_W-1:0]       cfg_data;
  int                              outstanding;
  int                              failures;

  bit                         quiet;
  bit                         stall_req;
  int                         tx_idle_pct;
  int                         rx_idle_pct;
  int                         step_max;
  int                         focus;
  logic [kpc_pkg::TIME_W-1:0] now_ms;
  bit                         key_down    [KEY_COUNT];
  logic [kpc_pkg::TIME_W-1:0] press_start [KEY_COUNT];
  logic [1:0]                 key_mode    [KEY_COUNT];

  key_press_classifier #(.KEY_COUNT(KEY_COUNT)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  kpc_event_checker #(.KEY_COUNT(KEY_COUNT)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .failures   (failures)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("key_press_classifier: mismatch");
    $finish;
  end

  // event sink: random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic put_report(input logic [kpc_pkg::KEY_W-1:0] key, input logic [1:0] raw,
                            input logic [kpc_pkg::TIME_W-1:0] pressed_at,
                            input logic [kpc_pkg::TIME_W-1:0] now,
                            input logic [1:0] mode);
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, mode, now, pressed_at, raw, key};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_timing(input logic [kpc_pkg::CFG_W-1:0] hold,
                                input logic [kpc_pkg::CFG_W-1:0] interval);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= kpc_pkg::CFG_HOLD_TIME;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_index <= kpc_pkg::CFG_REPEAT_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_max = int'(hold) / 4 + int'(interval) / 4 + 20;
  endtask

  // mostly well-formed press sessions on a few keys, plus noise and ignored keys
  task automatic random_report(output bit counted);
    int                        r;
    int                        k;
    logic [kpc_pkg::KEY_W-1:0] key;
    logic [1:0]                raw;
    r       = $urandom_range(0, 99);
    now_ms  = now_ms + $urandom_range(0, step_max);
    counted = 1'b1;
    if (r < 8) begin
      key     = kpc_pkg::KEY_W'($urandom);
      counted = (int'(key) < KEY_COUNT);
      put_report(key, 2'($urandom), $urandom, $urandom, 2'($urandom));
    end else if (r < 12) begin
      counted = 1'b0;
      put_report(kpc_pkg::KEY_W'($urandom_range(KEY_COUNT, 31)), kpc_pkg::RAW_PRESSED,
                 now_ms - 32'd1000, now_ms, 2'($urandom_range(0, 3)));
    end else begin
      if ($urandom_range(0, 3) != 0) k = (focus + int'($urandom_range(0, 3))) % KEY_COUNT;
      else k = int'($urandom_range(0, KEY_COUNT - 1));
      if (!key_down[k]) begin
        if ($urandom_range(0, 4) == 0) begin
          raw = ($urandom_range(0, 3) == 0) ? RAW_INVALID : RAW_IDLE;
          put_report(kpc_pkg::KEY_W'(k), raw, $urandom, now_ms, key_mode[k]);
        end else begin
          key_down[k]    = 1'b1;
          press_start[k] = now_ms - $urandom_range(0, 5);
          key_mode[k]    = 2'($urandom_range(0, 3));
          put_report(kpc_pkg::KEY_W'(k), kpc_pkg::RAW_PRESSED, press_start[k], now_ms,
                     key_mode[k]);
        end
      end else begin
        if ($urandom_range(0, 9) == 0) key_mode[k] = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
          key_down[k] = 1'b0;
          put_report(kpc_pkg::KEY_W'(k), kpc_pkg::RAW_RELEASED, press_start[k], now_ms,
                     key_mode[k]);
        end else begin
          put_report(kpc_pkg::KEY_W'(k), kpc_pkg::RAW_PRESSED, press_start[k], now_ms,
                     key_mode[k]);
        end
      end
    end
  endtask

  initial begin
    int                        done;
    bit                        counted;
    logic [kpc_pkg::CFG_W-1:0] hold_cfg;
    logic [kpc_pkg::CFG_W-1:0] interval_cfg;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_we      = 1'b0;
    cfg_index   = kpc_pkg::CFG_HOLD_TIME;
    cfg_data    = '0;
    quiet       = 1'b0;
    stall_req   = 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct = 15;
    step_max    = 500 / 4 + 125 / 4 + 20;
    focus       = 0;
    now_ms      = $urandom;
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_down[k]    = 1'b0;
      press_start[k] = '0;
      key_mode[k]    = kpc_pkg::MODE_SHORT;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, at reset timing: 500 ms hold, 125 ms repeat
    put_report(5'd0, kpc_pkg::RAW_PRESSED, 32'd0, 32'd200, kpc_pkg::MODE_SHORT);
    put_report(5'd0, kpc_pkg::RAW_PRESSED, 32'd0, 32'd300, kpc_pkg::MODE_SHORT);
    put_report(5'd0, kpc_pkg::RAW_PRESSED, 32'd0, 32'd501, kpc_pkg::MODE_SHORT);
    put_report(5'd0, kpc_pkg::RAW_RELEASED, 32'd0, 32'd600, kpc_pkg::MODE_SHORT);
    // hold across the time wrap, long event, then release after long
    put_report(5'd24, kpc_pkg::RAW_PRESSED, 32'hFFFF_FF00, 32'h0000_0100,
               kpc_pkg::MODE_SHORT_OR_LONG);
    put_report(5'd24, kpc_pkg::RAW_PRESSED, 32'hFFFF_FF00, 32'h0000_0180,
               kpc_pkg::MODE_SHORT_OR_LONG);
    put_report(5'd24, kpc_pkg::RAW_RELEASED, 32'hFFFF_FF00, 32'h0000_0200,
               kpc_pkg::MODE_SHORT_OR_LONG);
    put_report(5'd24, kpc_pkg::RAW_RELEASED, 32'd0, 32'h0000_0300,
               kpc_pkg::MODE_SHORT_OR_LONG);
    // keys out of range
    put_report(kpc_pkg::KEY_W'(KEY_COUNT), kpc_pkg::RAW_PRESSED, 32'd0, 32'd1000,
               kpc_pkg::MODE_SHORT);
    put_report(5'd31, RAW_INVALID, '1, '1, MODE_NONE);
    // raw state three, exact hold time, repeat gate at and past the interval
    put_report(5'd3, RAW_INVALID, 32'd0, 32'd900, kpc_pkg::MODE_SHORT_REPEATED);
    put_report(5'd3, kpc_pkg::RAW_PRESSED, 32'd1000, 32'd1000, kpc_pkg::MODE_SHORT_REPEATED);
    put_report(5'd3, kpc_pkg::RAW_PRESSED, 32'd1000, 32'd1500, kpc_pkg::MODE_SHORT_REPEATED);
    put_report(5'd3, kpc_pkg::RAW_PRESSED, 32'd1000, 32'd1600, kpc_pkg::MODE_SHORT_REPEATED);
    put_report(5'd3, kpc_pkg::RAW_PRESSED, 32'd1000, 32'd1725, kpc_pkg::MODE_SHORT_REPEATED);
    put_report(5'd3, kpc_pkg::RAW_PRESSED, 32'd1000, 32'd1726, kpc_pkg::MODE_SHORT_REPEATED);
    // mode none still tracks state
    put_report(5'd5, kpc_pkg::RAW_PRESSED, 32'd0, 32'd700, MODE_NONE);
    put_report(5'd5, kpc_pkg::RAW_RELEASED, 32'd0, 32'd800, kpc_pkg::MODE_SHORT_OR_LONG);
    put_report(5'd6, kpc_pkg::RAW_PRESSED, '1, '1, kpc_pkg::MODE_SHORT);
    put_report(5'd6, RAW_IDLE, 32'd0, 32'd0, kpc_pkg::MODE_SHORT);
    // short on release blocked by the repeat gate
    put_report(5'd7, kpc_pkg::RAW_RELEASED, 32'd0, 32'd100, kpc_pkg::MODE_SHORT_OR_LONG);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin hold_cfg = 16'd0;     interval_cfg = 16'd0;     end
        1: begin hold_cfg = 16'hFFFF;  interval_cfg = 16'hFFFF;  end
        2: begin
          hold_cfg     = 16'($urandom_range(20, 2000));
          interval_cfg = 16'($urandom_range(0, 500));
        end
        3: begin hold_cfg = 16'hFFFF;  interval_cfg = 16'd0;     end
        default: begin
          hold_cfg     = 16'($urandom_range(0, 1000));
          interval_cfg = 16'($urandom_range(0, 300));
        end
      endcase
      program_timing(hold_cfg, interval_cfg);
      case (ph)
        0: begin tx_idle_pct = 15; rx_idle_pct = 15; end
        1: begin tx_idle_pct = 0;  rx_idle_pct = 30; end
        2: begin tx_idle_pct = 30; rx_idle_pct = 0;  end
        3: begin tx_idle_pct = 10; rx_idle_pct = 20; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      quiet = (ph == PHASES - 1);
      if (ph == 0) stall_req = 1'b1;
      done = 0;
      while (done < PHASE_REPORTS) begin
        random_report(counted);
        if (counted) begin
          done++;
          if (done % 40 == 0) focus = int'($urandom_range(0, KEY_COUNT - 1));
        end
      end
    end

    wait_drained();
    if (failures == 0 && outstanding == 0) begin
      $display("key_press_classifier: match");
    end else begin
      $display("key_press_classifier: mismatch");
    end
    $finish;
  end

endmodule
